// File: hw/rtl/dedup_pkg.sv
// Shared definitions for the duplicate-detection table: field widths,
// request op codes and the packed entry layout.
// No dependencies.
`timescale 1ns / 1ps

package dedup_pkg;

  localparam int DIGEST_BYTES  = 20;
  localparam int DIGEST_W      = DIGEST_BYTES * 8;
  localparam int ID_W          = 64;
  localparam int DIG_HIGH_W    = 32;
  localparam int DIG_MID_W     = 64;
  localparam int DIG_LOW_W     = DIGEST_W - DIG_HIGH_W - DIG_MID_W;
  localparam int OP_W          = 2;
  localparam int OCC_W         = 7;
  localparam int DEFAULT_DEPTH = 64;

  localparam logic [OP_W-1:0] OP_LOOKUP_ID     = 2'd0;
  localparam logic [OP_W-1:0] OP_LOOKUP_DIGEST = 2'd1;
  localparam logic [OP_W-1:0] OP_REGISTER      = 2'd2;

  typedef struct packed {
    logic [ID_W-1:0]       file_id;
    logic [DIG_HIGH_W-1:0] digest_high;
    logic [DIG_MID_W-1:0]  digest_mid;
    logic [DIG_LOW_W-1:0]  digest_low;
  } entry_t;

endpackage

// File: hw/rtl/dedup_registry_fifo_table_top.sv
// Duplicate-detection table, top level: entry memory, scan sequencer and
// result register. Depends on dedup_pkg.
//
// Usage:
//   Request channel (req_valid / req_stall) carries op, file_id and the three
//   digest parts. Result channel (res_valid / res_stall) returns found and
//   occupancy, one result per request, in request order.
//   op 0 looks up an identifier, op 1 looks up a digest, op 2 stores a new
//   entry (oldest entry replaced once the table is full), op 3 does nothing.
//   One request is worked on at a time; req_stall stays high until its
//   result has been loaded into the result register.
//   A register or unused request passes from acceptance through the RESP
//   state to res_valid, which is set once the result register is free. A
//   lookup reads the entry memory one entry per cycle through its single
//   read port and ends early on the first match; an empty table answers
//   without a scan. req_stall drops in the cycle that res_valid rises.
//   Reset empties the table at once (entry count and ring pointer cleared);
//   no clearing pass is run. A stalled result holds in the result register
//   and the next finished result waits until it has been taken.
`timescale 1ns / 1ps

module dedup_registry_fifo_table_top #(
  parameter int TABLE_DEPTH = dedup_pkg::DEFAULT_DEPTH
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             req_valid,
  output logic                             req_stall,
  input  logic [dedup_pkg::OP_W-1:0]       op,
  input  logic [dedup_pkg::ID_W-1:0]       file_id,
  input  logic [dedup_pkg::DIG_HIGH_W-1:0] digest_high,
  input  logic [dedup_pkg::DIG_MID_W-1:0]  digest_mid,
  input  logic [dedup_pkg::DIG_LOW_W-1:0]  digest_low,
  output logic                             res_valid,
  input  logic                             res_stall,
  output logic                             found,
  output logic [dedup_pkg::OCC_W-1:0]      occupancy
);

  import dedup_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_RESP = 2'd2;

  entry_t mem [TABLE_DEPTH];
  entry_t rdata;
  entry_t req_entry;
  entry_t key;

  logic [1:0]    state;
  logic [1:0]    state_next;
  logic [OP_W-1:0] op_q;
  logic [CW-1:0] count;
  logic [AW-1:0] oldest;
  logic [CW-1:0] scan_idx;
  logic          rd_pend;
  logic          hit_q;

  logic          accept;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic          full;
  logic          rd_en;
  logic          cmp_match;
  logic          hit;
  logic          res_free;

  assign req_entry = '{file_id: file_id, digest_high: digest_high,
                       digest_mid: digest_mid, digest_low: digest_low};

  assign req_stall = (state != ST_IDLE);
  assign accept    = req_valid && !req_stall;
  assign full      = (count == CW'(TABLE_DEPTH));
  assign wr_en     = accept && (op == OP_REGISTER);
  assign wr_addr   = full ? oldest : count[AW-1:0];
  assign rd_en     = (state == ST_SCAN) && (scan_idx < count);
  assign res_free  = !res_valid || !res_stall;

  always_comb begin
    case (op_q)
      OP_LOOKUP_ID:     cmp_match = (rdata.file_id == key.file_id);
      OP_LOOKUP_DIGEST: cmp_match = (rdata.digest_high == key.digest_high) &&
                                    (rdata.digest_mid == key.digest_mid) &&
                                    (rdata.digest_low == key.digest_low);
      default:          cmp_match = 1'b0;
    endcase
  end

  assign hit = rd_pend && cmp_match;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if ((op inside {OP_LOOKUP_ID, OP_LOOKUP_DIGEST}) && (count != '0)) begin
            state_next = ST_SCAN;
          end else begin
            state_next = ST_RESP;
          end
        end
      end
      ST_SCAN: begin
        if (hit || !rd_en) begin
          state_next = ST_RESP;
        end
      end
      ST_RESP: begin
        if (res_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= req_entry;
    end
    if (rd_en) begin
      rdata <= mem[scan_idx[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q <= op;
      key  <= req_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      oldest    <= '0;
      scan_idx  <= '0;
      rd_pend   <= 1'b0;
      hit_q     <= 1'b0;
      res_valid <= 1'b0;
      found     <= 1'b0;
      occupancy <= '0;
    end else begin
      state   <= state_next;
      rd_pend <= rd_en;
      if (accept) begin
        scan_idx <= '0;
        hit_q    <= 1'b0;
      end else if (rd_en) begin
        scan_idx <= scan_idx + 1'b1;
      end
      if (state == ST_SCAN && hit) begin
        hit_q <= 1'b1;
      end
      if (wr_en) begin
        if (full) begin
          oldest <= (oldest == AW'(TABLE_DEPTH - 1)) ? '0 : oldest + 1'b1;
        end else begin
          count <= count + 1'b1;
        end
      end
      if (state == ST_RESP && res_free) begin
        res_valid <= 1'b1;
        found     <= hit_q;
        occupancy <= OCC_W'(count);
      end else if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(TABLE_DEPTH))
    else $error("entry count above table depth");

  a_oldest_full: assert property (@(posedge clk) disable iff (rst)
    (oldest != '0) |-> full)
    else $error("ring pointer moved before table filled");

  a_fill: assert property (@(posedge clk) disable iff (rst)
    (wr_en && !full) |=> (count == $past(count) + 1'b1))
    else $error("register request did not grow the table");

  a_evict: assert property (@(posedge clk) disable iff (rst)
    (wr_en && full) |=> (full && (oldest != $past(oldest))))
    else $error("register request on full table did not advance oldest slot");

  a_scan_idx: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (scan_idx <= count))
    else $error("scan index beyond valid entries");

endmodule
